// ----- rtl/psli_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package psli_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int OPCODE_W = 1;
    localparam int INDEX_W  = 10;
    localparam int ENTRY_W  = 31;
    localparam int POS_W    = 32;
    localparam int COUNT_W  = 11;
    localparam int SEG_W    = 10;
    localparam int FRAC_W   = 17;

    localparam logic [OPCODE_W-1:0] OP_LOAD  = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_QUERY = 1'b1;

    localparam logic [COUNT_W-1:0] POINT_COUNT_RST = 11'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH,
        ST_RDA,
        ST_RDB,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic               start;
        logic [ENTRY_W-1:0] num;
        logic [ENTRY_W-1:0] den;
    } t_div_req;

endpackage
`default_nettype wire

// ----- rtl/path_segment_locate_interp_top.sv -----
// Path segment locator with linear interpolation.
// Input words (i_in_valid / o_in_stall) are either loads, which write one
// arc-length entry of the table, or queries, which search the first
// point_count entries (clamped to 2..MAX_POINTS) and return one output
// word (o_out_valid / i_out_stall) with found, segment index and
// Q1.FRAC_BITS fraction. Loads produce no output word.
// A query takes ceil(log2(n+1)) table reads for the lower-bound search
// (one read per cycle from the table's single read port), two reads for
// the segment ends, a pass through the restoring fraction divider and a
// write of the output register; the divider is skipped when the fraction
// is 0 or full scale or the position is outside. The next word is accepted
// in the cycle after the result is registered. One query is in flight at
// a time; o_in_stall is high while it runs.
// The result sits in the output register; while the receiver stalls the
// next query still runs and waits only for the register to free up.
// Reset clears the control state and sets point_count to 2; the table
// holds nothing defined until loaded. point_count is written through
// i_cfg_we / i_cfg_data; the user must do so only while the block is
// idle, since the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module path_segment_locate_interp_top #(
    parameter int MAX_POINTS = psli_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = psli_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic        [psli_pkg::COUNT_W-1:0]  i_cfg_data,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic        [psli_pkg::OPCODE_W-1:0] i_opcode,
    input  wire logic        [psli_pkg::INDEX_W-1:0]  i_entry_index,
    input  wire logic        [psli_pkg::ENTRY_W-1:0]  i_entry_value,
    input  wire logic signed [psli_pkg::POS_W-1:0]    i_query_pos,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic                                      o_found,
    output logic             [psli_pkg::SEG_W-1:0]    o_segment_index,
    output logic             [psli_pkg::FRAC_W-1:0]   o_fraction
);
    import psli_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    t_state r_state, n_state;

    logic [COUNT_W-1:0]      r_point_count;
    logic signed [POS_W-1:0] r_s;
    logic [CW-1:0]           r_n;
    logic [CW-1:0]           r_lo;
    logic [CW-1:0]           r_len;
    logic [CW-1:0]           r_idx;
    logic [ENTRY_W-1:0]      r_a;
    logic                    r_found;
    logic [CW-1:0]           r_seg;
    logic [FRAC_BITS:0]      r_frac;

    logic                    r_out_valid;
    logic                    r_o_found;
    logic [SEG_W-1:0]        r_o_seg;
    logic [FRAC_W-1:0]       r_o_frac;

    logic [ENTRY_W-1:0]      tbl_rdata;
    logic [AW-1:0]           rd_addr;
    logic                    tbl_we;

    logic [31:0]             pc_ext;
    logic [31:0]             n_clamp;
    logic [CW-1:0]           q_n;

    logic [CW-1:0]           half;
    logic                    probe_lt;
    logic [CW-1:0]           s_lo_nx;
    logic [CW-1:0]           s_len_nx;
    logic [CW-1:0]           s_idx;

    logic signed [POS_W:0]   num33;
    logic signed [POS_W-1:0] den32;
    logic                    found_c;
    logic                    num_pos;
    logic                    den_pos;
    logic                    num_ge;

    t_div_req                div_req;
    logic                    div_done;
    logic [FRAC_BITS-1:0]    div_quot;

    logic                    accept;
    logic                    out_free;
    logic [31:0]             seg_ext;
    logic [31:0]             frac_ext;

    assign accept   = (r_state == ST_IDLE) && i_in_valid;
    assign out_free = !r_out_valid || !i_out_stall;
    assign tbl_we   = accept && (i_opcode == OP_LOAD)
                      && (32'(i_entry_index) < 32'(MAX_POINTS));

    always_comb begin
        pc_ext = 32'(r_point_count);
        if (pc_ext < 32'd2) begin
            n_clamp = 32'd2;
        end else if (pc_ext > 32'(MAX_POINTS)) begin
            n_clamp = 32'(MAX_POINTS);
        end else begin
            n_clamp = pc_ext;
        end
        q_n = CW'(n_clamp);
    end

    always_comb begin
        half     = r_len >> 1;
        probe_lt = $signed({1'b0, tbl_rdata}) < r_s;
        s_lo_nx  = probe_lt ? r_lo + half + CW'(1) : r_lo;
        s_len_nx = probe_lt ? r_len - half - CW'(1) : half;
        s_idx    = (s_lo_nx == '0) ? '0 : s_lo_nx - CW'(1);
    end

    always_comb begin
        num33   = {r_s[POS_W-1], r_s} - $signed({2'b00, r_a});
        den32   = $signed({1'b0, tbl_rdata}) - $signed({1'b0, r_a});
        found_c = (r_lo < r_n) && ((r_lo != '0) || (r_s >= $signed({1'b0, r_a})));
        num_pos = !num33[POS_W] && (num33 != '0);
        den_pos = !den32[POS_W-1] && (den32 != '0);
        num_ge  = num33 >= {den32[POS_W-1], den32};
    end

    always_comb begin
        n_state       = r_state;
        rd_addr       = '0;
        div_req.start = 1'b0;
        div_req.num   = num33[ENTRY_W-1:0];
        div_req.den   = den32[ENTRY_W-1:0];
        unique case (r_state)
            ST_IDLE: begin
                rd_addr = AW'(q_n >> 1);
                if (i_in_valid && (i_opcode == OP_QUERY)) begin
                    n_state = ST_SRCH;
                end
            end
            ST_SRCH: begin
                if (s_len_nx == '0) begin
                    rd_addr = AW'(s_idx);
                    n_state = ST_RDA;
                end else begin
                    rd_addr = AW'(s_lo_nx + (s_len_nx >> 1));
                end
            end
            ST_RDA: begin
                rd_addr = AW'(r_idx + CW'(1));
                n_state = ST_RDB;
            end
            ST_RDB: begin
                if (found_c && num_pos && den_pos && !num_ge) begin
                    div_req.start = 1'b1;
                    n_state       = ST_DIV;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_out_valid   <= 1'b0;
            r_point_count <= POINT_COUNT_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_point_count <= i_cfg_data;
            end
            if ((r_state == ST_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_s   <= i_query_pos;
                r_n   <= q_n;
                r_lo  <= '0;
                r_len <= q_n;
            end
            ST_SRCH: begin
                r_lo  <= s_lo_nx;
                r_len <= s_len_nx;
                r_idx <= s_idx;
            end
            ST_RDA: begin
                r_a <= tbl_rdata;
            end
            ST_RDB: begin
                r_found <= found_c;
                r_seg   <= found_c ? r_idx : '0;
                if (found_c && num_pos && den_pos && num_ge) begin
                    r_frac <= {1'b1, {FRAC_BITS{1'b0}}};
                end else begin
                    r_frac <= '0;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    r_frac <= {1'b0, div_quot};
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    r_o_found <= r_found;
                    r_o_seg   <= seg_ext[SEG_W-1:0];
                    r_o_frac  <= frac_ext[FRAC_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    assign seg_ext  = 32'(r_seg);
    assign frac_ext = 32'(r_frac);

    psli_table #(
        .DEPTH(MAX_POINTS),
        .AW   (AW)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (tbl_we),
        .i_waddr(AW'(i_entry_index)),
        .i_wdata(i_entry_value),
        .i_raddr(rd_addr),
        .o_rdata(tbl_rdata)
    );

    psli_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_done (div_done),
        .o_quot (div_quot)
    );

    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_found         = r_o_found;
    assign o_segment_index = r_o_seg;
    assign o_fraction      = r_o_frac;

endmodule
`default_nettype wire

// ----- rtl/psli_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
module psli_table #(
    parameter int DEPTH = psli_pkg::MAX_POINTS_DEF,
    parameter int AW    = $clog2(psli_pkg::MAX_POINTS_DEF)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_we,
    input  wire logic [AW-1:0]                i_waddr,
    input  wire logic [psli_pkg::ENTRY_W-1:0] i_wdata,
    input  wire logic [AW-1:0]                i_raddr,
    output logic      [psli_pkg::ENTRY_W-1:0] o_rdata
);
    import psli_pkg::*;

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- rtl/psli_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module psli_div #(
    parameter int FRAC_BITS = psli_pkg::FRAC_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire psli_pkg::t_div_req   i_req,
    output logic                      o_done,
    output logic [FRAC_BITS-1:0]      o_quot
);
    import psli_pkg::*;

    localparam int CNTW = $clog2(FRAC_BITS);

    logic                 r_busy;
    logic                 r_done;
    logic [CNTW-1:0]      r_cnt;
    logic [ENTRY_W-1:0]   r_rem;
    logic [ENTRY_W-1:0]   r_den;
    logic [FRAC_BITS-1:0] r_quot;

    logic [ENTRY_W:0]     rem2;
    logic [ENTRY_W:0]     rem_nx;
    logic                 ge;

    always_comb begin
        rem2   = {r_rem, 1'b0};
        ge     = rem2 >= {1'b0, r_den};
        rem_nx = ge ? rem2 - {1'b0, r_den} : rem2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(FRAC_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.num;
            r_den  <= i_req.den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= rem_nx[ENTRY_W-1:0];
            r_quot <= {r_quot[FRAC_BITS-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
`default_nettype wire
